// File: hw/rtl/srp_pkg.sv
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types and constants of the shelf rectangle packer.
// ----------------------------------------------------------------------------
package srp_pkg;

	localparam int DIM_W        = 13;
	localparam int POS_W        = 12;
	localparam int CW           = 14;
	localparam int ADDR_W       = 3;
	localparam int DATA_W       = 32;
	localparam int MAX_SIDE_DEF = 4096;
	localparam int SIDE_RESET   = 1024;
	localparam int POS_MAX      = (1 << POS_W) - 1;

	localparam logic REG_ATLAS_SIDE = 1'b0;

	typedef struct packed {
		logic             start_new;
		logic [DIM_W-1:0] rect_width;
		logic [DIM_W-1:0] rect_height;
	} srp_req_t;

	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic             placed;
	} srp_rsp_t;

	typedef struct packed {
		logic          have_shelf;
		logic [CW-1:0] shelf_top;
		logic [CW-1:0] shelf_height;
		logic [CW-1:0] next_x;
		logic [CW-1:0] shelf_free_width;
		logic [CW-1:0] free_height;
		logic          failed;
	} srp_state_t;

	function automatic logic [POS_W-1:0] sat_pos(input logic [CW-1:0] v);
		logic [POS_W-1:0] r;
		if (v > CW'(POS_MAX)) begin
			r = POS_W'(POS_MAX);
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/srp_if.sv
// ----------------------------------------------------------------------------
// srp_req_if / srp_rsp_if
// Valid/ready channels carrying packer requests and placement results.
// ----------------------------------------------------------------------------
interface srp_req_if import srp_pkg::*; ();
	logic     valid;
	logic     ready;
	srp_req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface srp_rsp_if import srp_pkg::*; ();
	logic     valid;
	logic     ready;
	srp_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/shelf_rectangle_packer_unit.sv
// A request is registered in the input stage, and its result in the output stage.
// Throughput: one request per cycle; the next shelf state is computed combinationally
//   from the input register, so back-to-back requests wait only while
//   a result is held off by the receiver.
// Reset (arst_n low, asynchronous): atlas_side = 1024, shelf state cleared,
//   free height = side in use, both pipeline stages empty.
// ----------------------------------------------------------------------------
// shelf_rectangle_packer_unit
// Shelf next-fit rectangle packer with one pixel of padding.
// ----------------------------------------------------------------------------
module shelf_rectangle_packer_unit import srp_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	srp_req_if.sink           req,
	srp_rsp_if.source         rsp
);

	localparam logic [CW-1:0] SIDE_CAP = (MAX_SIDE > (1 << DIM_W) - 1) ?
		CW'((1 << DIM_W) - 1) : CW'(MAX_SIDE);
	localparam logic [CW-1:0] FREE_RST = (SIDE_RESET > MAX_SIDE) ?
		CW'(MAX_SIDE) : CW'(SIDE_RESET);
	localparam srp_state_t    ST_RST   = '{
		have_shelf: 1'b0, shelf_top: '0, shelf_height: '0, next_x: '0,
		shelf_free_width: '0, free_height: FREE_RST, failed: 1'b0
	};

	logic [DIM_W-1:0] atlas_side_q;
	srp_state_t       st_q;
	srp_state_t       cur;
	srp_state_t       nxt;
	srp_req_t         req_s1;
	logic             vld_s1;
	srp_rsp_t         rsp_s2;
	logic             vld_s2;
	logic             adv;
	logic [CW-1:0]    side;
	logic [CW-1:0]    w;
	logic [CW-1:0]    h;
	logic [CW-1:0]    w1;
	logic [CW-1:0]    pos_x;
	logic [CW-1:0]    pos_y;
	logic             ok;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ATLAS_SIDE) ? DATA_W'(atlas_side_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_side_q <= DIM_W'(SIDE_RESET);
		end else if (psel && penable && pwrite && paddr[2] == REG_ATLAS_SIDE) begin
			atlas_side_q <= pwdata[DIM_W-1:0];
		end
	end

	assign side = (CW'(atlas_side_q) > SIDE_CAP) ? SIDE_CAP : CW'(atlas_side_q);

	// pipeline control
	assign adv       = !vld_s2 || rsp.ready;
	assign req.ready = !vld_s1 || adv;
	assign rsp.valid = vld_s2;
	assign rsp.data  = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
	end

	// placement
	assign w  = CW'(req_s1.rect_width);
	assign h  = CW'(req_s1.rect_height);
	assign w1 = w + CW'(1);

	always_comb begin
		logic [CW-1:0] diff;
		logic [CW-1:0] need;
		cur = st_q;
		if (req_s1.start_new) begin
			cur = '0;
			cur.free_height = side;
		end
		nxt   = cur;
		pos_x = '0;
		pos_y = '0;
		ok    = 1'b0;
		diff  = h - cur.shelf_height;
		need  = h + CW'(cur.have_shelf);
		if (!cur.failed) begin
			if (w > side || h > side) begin
				nxt.failed = 1'b1;
			end else if (cur.have_shelf && cur.shelf_free_width >= w1) begin
				if (h > cur.shelf_height && cur.free_height < diff) begin
					nxt.failed = 1'b1;
				end else begin
					ok                   = 1'b1;
					pos_x                = cur.next_x;
					pos_y                = cur.shelf_top;
					nxt.shelf_free_width = cur.shelf_free_width - w1;
					nxt.next_x           = cur.next_x + w1;
					if (h > cur.shelf_height) begin
						nxt.free_height  = cur.free_height - diff;
						nxt.shelf_height = h;
					end
				end
			end else if (cur.free_height < need) begin
				nxt.failed = 1'b1;
			end else begin
				ok                   = 1'b1;
				nxt.free_height      = cur.free_height - need;
				nxt.shelf_top        = cur.have_shelf ?
					cur.shelf_top + cur.shelf_height + CW'(1) : '0;
				nxt.have_shelf       = 1'b1;
				nxt.shelf_height     = h;
				nxt.shelf_free_width = side - w;
				nxt.next_x           = w1;
				pos_y                = nxt.shelf_top;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_RST;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
			if (vld_s1) begin
				st_q <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			rsp_s2.pos_x  <= sat_pos(pos_x);
			rsp_s2.pos_y  <= sat_pos(pos_y);
			rsp_s2.placed <= ok;
		end
	end

`ifndef SYNTHESIS
	a_sticky_fail: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv && st_q.failed && !req_s1.start_new |=> !rsp_s2.placed)
		else $error("result placed during sticky failure");

	a_no_shelf_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.have_shelf |-> st_q.shelf_top == '0 && st_q.next_x == '0)
		else $error("shelf state set without an open shelf");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1 && $stable(req_s1))
		else $error("input stage lost a request under stall");
`endif

endmodule

// File: tb/srp_placement_checker.sv
// ----------------------------------------------------------------------------
// srp_placement_checker
// Watches the request, result and register channels of the shelf packer.
// Keeps its own copy of the shelf state and atlas side, predicts the
// placement of every accepted request and checks the results in order.
// ----------------------------------------------------------------------------
module srp_placement_checker import srp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              pready,
	srp_req_if                req,
	srp_rsp_if                rsp,
	output int                errors,
	output int                pending
);

	int unsigned atlas_side;
	bit          have_shelf;
	int unsigned shelf_top;
	int unsigned shelf_height;
	int unsigned next_x;
	int unsigned shelf_free_width;
	int unsigned free_height;
	bit          failed;
	srp_rsp_t    expected_placements[$];

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic int unsigned side_in_use();
		return (atlas_side > MAX_SIDE_DEF) ? MAX_SIDE_DEF : atlas_side;
	endfunction

	function automatic void clear_shelves();
		have_shelf = 1'b0;
		shelf_top = 0;
		shelf_height = 0;
		next_x = 0;
		shelf_free_width = 0;
		free_height = side_in_use();
		failed = 1'b0;
	endfunction

	function automatic srp_rsp_t predict_placement(input srp_req_t r);
		int unsigned w;
		int unsigned h;
		int unsigned side;
		int unsigned need;
		int unsigned x;
		int unsigned y;
		srp_rsp_t    res;
		w = r.rect_width;
		h = r.rect_height;
		res = '0;
		if (r.start_new) begin
			clear_shelves();
		end
		if (failed) begin
			return res;
		end
		side = side_in_use();
		if (w > side || h > side) begin
			failed = 1'b1;
			return res;
		end
		if (have_shelf && shelf_free_width >= w + 1) begin
			x = next_x;
			y = shelf_top;
			shelf_free_width -= w + 1;
			next_x += w + 1;
			if (h > shelf_height) begin
				if (free_height < h - shelf_height) begin
					failed = 1'b1;
					return res;
				end
				free_height -= h - shelf_height;
				shelf_height = h;
			end
		end else begin
			need = h + (have_shelf ? 1 : 0);
			if (free_height < need) begin
				failed = 1'b1;
				return res;
			end
			free_height -= need;
			shelf_top = have_shelf ? shelf_top + shelf_height + 1 : 0;
			have_shelf = 1'b1;
			shelf_height = h;
			shelf_free_width = side - w;
			next_x = w + 1;
			x = 0;
			y = shelf_top;
		end
		res.pos_x = (x > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(x);
		res.pos_y = (y > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(y);
		res.placed = 1'b1;
		return res;
	endfunction

	task automatic note_mismatch(input string msg);
		$display("placement mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		srp_rsp_t want;
		if (!arst_n) begin
			atlas_side = SIDE_RESET;
			clear_shelves();
			expected_placements.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_ATLAS_SIDE) begin
				atlas_side = pwdata[DIM_W-1:0];
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_placements.size() == 0) begin
					note_mismatch("result with no request outstanding");
				end else begin
					want = expected_placements.pop_front();
					if (rsp.data.pos_x !== want.pos_x) begin
						note_mismatch($sformatf("pos_x %0d, expected %0d",
							rsp.data.pos_x, want.pos_x));
					end
					if (rsp.data.pos_y !== want.pos_y) begin
						note_mismatch($sformatf("pos_y %0d, expected %0d",
							rsp.data.pos_y, want.pos_y));
					end
					if (rsp.data.placed !== want.placed) begin
						note_mismatch($sformatf("placed %b, expected %b",
							rsp.data.placed, want.placed));
					end
				end
			end
			if (req.valid && req.ready) begin
				expected_placements.insert(expected_placements.size(),
					predict_placement(req.data));
			end
		end
		pending = expected_placements.size();
	end

endmodule

// File: tb/tb_shelf_rectangle_packer_unit.sv
// ----------------------------------------------------------------------------
// tb_shelf_rectangle_packer_unit
// Drives the shelf packer with directed corner cases and random packing
// sequences over several atlas sides, with random stalls on both channels.
// The checker beside the block predicts and compares every placement.
// ----------------------------------------------------------------------------
module tb_shelf_rectangle_packer_unit import srp_pkg::*; ();

	localparam int                CYCLE_LIMIT = 200000;
	localparam int                HOLD_CYCLES = 300;
	localparam logic [ADDR_W-1:0] SIDE_ADDR   = ADDR_W'({REG_ATLAS_SIDE, 2'b00});
	localparam logic [ADDR_W-1:0] SPARE_ADDR  = SIDE_ADDR + ADDR_W'(4);

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                errors;
	int                pending;
	int                cycle_count = 0;
	bit                no_idle = 1'b0;
	bit                hold_trig = 1'b0;
	int unsigned       seq_left = 0;
	int unsigned       cur_h = 0;

	srp_req_if req_ch ();
	srp_rsp_if rsp_ch ();

	shelf_rectangle_packer_unit dut (
		.clk,
		.arst_n,
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready,
		.req(req_ch),
		.rsp(rsp_ch)
	);

	srp_placement_checker chk (
		.clk,
		.arst_n,
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.pready,
		.req(req_ch),
		.rsp(rsp_ch),
		.errors,
		.pending
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin : result_ready
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_trig && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= no_idle || ($urandom_range(99) >= 10);
			end
		end
	end

	function automatic srp_req_t rect_req(input bit start, input int unsigned w,
			input int unsigned h);
		srp_req_t r;
		r.start_new = start;
		r.rect_width = DIM_W'(w);
		r.rect_height = DIM_W'(h);
		return r;
	endfunction

	// mostly well-formed sequences: start, then heights mostly descending
	function automatic srp_req_t random_rect(input int unsigned side);
		int unsigned s;
		int unsigned wmax;
		int unsigned drop;
		bit          start;
		s = (side > MAX_SIDE_DEF) ? MAX_SIDE_DEF : side;
		if ($urandom_range(99) < 8) begin
			return rect_req(1'($urandom_range(1)), $urandom, $urandom);
		end
		start = (seq_left == 0);
		if (start) begin
			seq_left = $urandom_range(4, 40);
			cur_h = $urandom_range(0, s / 3);
		end
		seq_left--;
		wmax = s >> $urandom_range(0, 4);
		if ($urandom_range(99) < 15) begin
			cur_h = cur_h + $urandom_range(0, 8);
		end else begin
			drop = $urandom_range(0, cur_h / 4 + 1);
			cur_h = (drop > cur_h) ? 0 : cur_h - drop;
		end
		return rect_req(start, $urandom_range(0, wmax), cur_h);
	endfunction

	task automatic push(input srp_req_t r);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 10) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		wait (pending == 0);
	endtask

	task automatic set_side(input logic [ADDR_W-1:0] addr, input int unsigned value);
		drain();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned side;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// reset side: join, growth, new shelf
		push(rect_req(1, 100, 50));
		push(rect_req(0, 200, 40));
		push(rect_req(0, 50, 60));
		push(rect_req(0, 800, 30));
		// side change in the middle of a packing, spare address ignored
		set_side(SIDE_ADDR, 2048);
		set_side(SPARE_ADDR, 5);
		push(rect_req(0, 1500, 30));
		push(rect_req(0, 1100, 5));
		push(rect_req(0, 2049, 0));
		push(rect_req(0, 1, 1));
		push(rect_req(1, 2048, 2048));
		push(rect_req(0, 0, 0));
		push(rect_req(1, 8191, 1));
		push(rect_req(1, 0, 8191));
		// far edge: coordinates saturate, then shelf growth overflows
		set_side(SIDE_ADDR, 4096);
		push(rect_req(1, 4095, 4095));
		push(rect_req(0, 0, 0));
		push(rect_req(0, 0, 0));
		push(rect_req(0, 0, 1));
		set_side(SIDE_ADDR, 0);
		push(rect_req(1, 0, 0));
		push(rect_req(0, 0, 0));
		push(rect_req(1, 1, 0));
		set_side(SIDE_ADDR, 8191);
		push(rect_req(1, 4096, 4096));
		push(rect_req(1, 4097, 1));
		set_side(SIDE_ADDR, 1);
		push(rect_req(1, 0, 0));
		push(rect_req(0, 0, 1));

		for (int p = 0; p < 12; p++) begin
			case (p)
				0: begin
					side = SIDE_RESET;
				end
				1: begin
					side = MAX_SIDE_DEF;
				end
				2: begin
					side = 16;
				end
				3: begin
					side = 1;
				end
				4: begin
					side = 0;
				end
				5: begin
					side = 8191;
				end
				default: begin
					side = ($urandom_range(3) == 0) ? $urandom_range(0, 8191)
						: $urandom_range(1, 4096);
				end
			endcase
			set_side(SIDE_ADDR, side);
			no_idle = (p == 7);
			for (int i = 0; i < 155; i++) begin
				if (p == 6 && i == 40) begin
					hold_trig = 1'b1;
				end
				push(random_rect(side));
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/srp_pkg.sv
hw/rtl/srp_if.sv
hw/rtl/shelf_rectangle_packer_unit.sv
tb/srp_placement_checker.sv
tb/tb_shelf_rectangle_packer_unit.sv
